>>> sv/mlk_pkg.sv
package mlk_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned UnitMax    = 2400;
  localparam int unsigned UnitReset  = 240;

  typedef logic [4:0]  letter_idx_t;
  typedef logic [11:0] unit_t;
  typedef logic [12:0] ms_t;
  typedef logic [6:0]  rom_entry_t;

  typedef struct packed {
    logic [3:0] pattern;
    logic [2:0] len;
    logic       eom;
  } letter_t;

  // length in bits 6..4, elements in bits 3..0, first element at bit 0, 1 is a dash
  function automatic rom_entry_t rom_lookup(input letter_idx_t idx);
    rom_entry_t entry;
    unique case (idx)
      5'd0:    entry = 7'h22;
      5'd1:    entry = 7'h41;
      5'd2:    entry = 7'h45;
      5'd3:    entry = 7'h31;
      5'd4:    entry = 7'h10;
      5'd5:    entry = 7'h44;
      5'd6:    entry = 7'h33;
      5'd7:    entry = 7'h40;
      5'd8:    entry = 7'h20;
      5'd9:    entry = 7'h4E;
      5'd10:   entry = 7'h35;
      5'd11:   entry = 7'h42;
      5'd12:   entry = 7'h23;
      5'd13:   entry = 7'h21;
      5'd14:   entry = 7'h37;
      5'd15:   entry = 7'h46;
      5'd16:   entry = 7'h4B;
      5'd17:   entry = 7'h32;
      5'd18:   entry = 7'h30;
      5'd19:   entry = 7'h11;
      5'd20:   entry = 7'h34;
      5'd21:   entry = 7'h48;
      5'd22:   entry = 7'h36;
      5'd23:   entry = 7'h49;
      5'd24:   entry = 7'h4D;
      5'd25:   entry = 7'h43;
      default: entry = 7'h00;
    endcase
    return entry;
  endfunction

endpackage

>>> sv/mlk_if.sv
interface mlk_in_if;
  logic                  valid;
  logic                  ready;
  mlk_pkg::letter_idx_t  letter_index;
  logic                  end_of_message;

  modport source(output valid, letter_index, end_of_message, input ready);
  modport sink(input valid, letter_index, end_of_message, output ready);
endinterface

interface mlk_out_if;
  logic          valid;
  logic          ready;
  logic          is_dash;
  mlk_pkg::ms_t  on_ms;
  mlk_pkg::ms_t  off_ms;
  logic          last_of_letter;
  logic          message_done;

  modport source(output valid, is_dash, on_ms, off_ms, last_of_letter, message_done,
                 input ready);
  modport sink(input valid, is_dash, on_ms, off_ms, last_of_letter, message_done,
               output ready);
endinterface

interface mlk_cfg_if;
  logic            valid;
  logic            ready;
  mlk_pkg::unit_t  unit_ms;

  modport source(output valid, unit_ms, input ready);
  modport sink(input valid, unit_ms, output ready);
endinterface

>>> sv/mlk_front.sv
module mlk_front (
  mlk_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             push,
  output mlk_pkg::letter_t push_data
);

  mlk_pkg::rom_entry_t entry;
  logic                known;

  assign entry     = mlk_pkg::rom_lookup(in_ch.letter_index);
  assign known     = in_ch.letter_index < 5'(mlk_pkg::NumLetters);
  assign in_ch.ready = !q_full;

  // drop unknown letters together with their end mark
  assign push = in_ch.valid && !q_full && known;

  assign push_data.pattern = entry[3:0];
  assign push_data.len     = entry[6:4];
  assign push_data.eom     = in_ch.end_of_message;

endmodule

>>> sv/mlk_queue.sv
module mlk_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mlk_pkg::letter_t push_data,
  input  logic             pop,
  output logic             q_valid,
  output logic             q_full,
  output mlk_pkg::letter_t q_head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mlk_pkg::letter_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign q_valid = count_r != '0;
  assign q_full  = count_r == CW'(DEPTH);
  assign q_head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/mlk_back.sv
module mlk_back (
  input  logic             clk,
  input  logic             rst_n,
  mlk_cfg_if.sink          cfg_ch,
  input  logic             q_valid,
  input  mlk_pkg::letter_t q_head,
  output logic             pop,
  mlk_out_if.source        out_ch
);

  mlk_pkg::unit_t unit_r, unit_nxt;
  mlk_pkg::ms_t   unit3_r, unit3_nxt;
  mlk_pkg::unit_t wr_unit;

  logic       cur_valid_r, cur_valid_nxt;
  logic [3:0] cur_pat_r, cur_pat_nxt;
  logic [2:0] cur_rem_r, cur_rem_nxt;
  logic       cur_eom_r, cur_eom_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic         is_dash_r, is_dash_nxt;
  mlk_pkg::ms_t on_ms_r, on_ms_nxt;
  mlk_pkg::ms_t off_ms_r, off_ms_nxt;
  logic         last_r, last_nxt;
  logic         done_r, done_nxt;

  logic load_ok;
  logic emit;
  logic cur_last;

  assign cfg_ch.ready = 1'b1;

  // clamp the unit to 1..UnitMax at write time
  always_comb begin
    priority if (cfg_ch.unit_ms == '0) begin
      wr_unit = 12'd1;
    end else if (cfg_ch.unit_ms > 12'(mlk_pkg::UnitMax)) begin
      wr_unit = 12'(mlk_pkg::UnitMax);
    end else begin
      wr_unit = cfg_ch.unit_ms;
    end
  end

  always_comb begin
    unit_nxt  = unit_r;
    unit3_nxt = unit3_r;
    if (cfg_ch.valid) begin
      unit_nxt  = wr_unit;
      unit3_nxt = {1'b0, wr_unit} + {wr_unit, 1'b0};
    end
  end

  assign load_ok  = !out_valid_r || out_ch.ready;
  assign emit     = load_ok && cur_valid_r;
  assign cur_last = cur_rem_r == 3'd1;
  assign pop      = q_valid && (!cur_valid_r || (emit && cur_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_pat_nxt   = cur_pat_r;
    cur_rem_nxt   = cur_rem_r;
    cur_eom_nxt   = cur_eom_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_pat_nxt   = q_head.pattern;
      cur_rem_nxt   = q_head.len;
      cur_eom_nxt   = q_head.eom;
    end else if (emit && cur_last) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      cur_pat_nxt = {1'b0, cur_pat_r[3:1]};
      cur_rem_nxt = cur_rem_r - 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    is_dash_nxt   = is_dash_r;
    on_ms_nxt     = on_ms_r;
    off_ms_nxt    = off_ms_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      is_dash_nxt   = cur_pat_r[0];
      on_ms_nxt     = cur_pat_r[0] ? unit3_r : {1'b0, unit_r};
      off_ms_nxt    = cur_last ? unit3_r : {1'b0, unit_r};
      last_nxt      = cur_last;
      done_nxt      = cur_last && cur_eom_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r      <= 12'(mlk_pkg::UnitReset);
      unit3_r     <= 13'(3 * mlk_pkg::UnitReset);
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unit_r      <= unit_nxt;
      unit3_r     <= unit3_nxt;
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pat_r <= cur_pat_nxt;
    cur_rem_r <= cur_rem_nxt;
    cur_eom_r <= cur_eom_nxt;
    is_dash_r <= is_dash_nxt;
    on_ms_r   <= on_ms_nxt;
    off_ms_r  <= off_ms_nxt;
    last_r    <= last_nxt;
    done_r    <= done_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_dash        = is_dash_r;
  assign out_ch.on_ms          = on_ms_r;
  assign out_ch.off_ms         = off_ms_r;
  assign out_ch.last_of_letter = last_r;
  assign out_ch.message_done   = done_r;

endmodule

>>> sv/morse_letter_keyer.sv
// A letter's first element passes the letter queue and the current-letter register before
// it is registered on the result channel. Throughput: one element per cycle while the result
// channel is ready; a letter holds the sender while its elements (1 to 4) are sent, and the
// letter queue absorbs requests meanwhile. Unknown indexes are accepted and produce nothing.
// Reset (rst_n low, synchronous) empties the queue and output stage and sets the unit to 240 ms.
module morse_letter_keyer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  mlk_cfg_if.sink    cfg_ch,
  mlk_in_if.sink     in_ch,
  mlk_out_if.source  out_ch
);

  logic             push;
  mlk_pkg::letter_t push_data;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  mlk_pkg::letter_t q_head;

  mlk_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mlk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_head    (q_head)
  );

  mlk_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> sv/mlk_checker.sv
module mlk_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input logic         is_dash,
  input mlk_pkg::ms_t on_ms,
  input mlk_pkg::ms_t off_ms,
  input logic         last_of_letter,
  input logic         message_done
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(on_ms) && $stable(off_ms)
      && $stable(is_dash) && $stable(last_of_letter) && $stable(message_done))
    else $error("stalled result changed");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_done |-> last_of_letter)
    else $error("message end on a non-final element");

  a_gap_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (is_dash == last_of_letter) |-> on_ms == off_ms)
    else $error("on and off times disagree with element kind");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> on_ms != '0 && off_ms != '0)
    else $error("zero length element");

endmodule

bind morse_letter_keyer mlk_checker u_mlk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .is_dash        (out_ch.is_dash),
  .on_ms          (out_ch.on_ms),
  .off_ms         (out_ch.off_ms),
  .last_of_letter (out_ch.last_of_letter),
  .message_done   (out_ch.message_done)
);
